// ----- hw/rtl/edtq_pkg.sv -----
// ----------------------------------------------------------------------------
// edtq_pkg: shared types and constants of the earliest-deadline timer queue
// Holds the action codes, the classified command, the result beat and the
// saturation helper for the pending count.
// ----------------------------------------------------------------------------
package edtq_pkg;

   localparam int ACTION_W   = 2;
   localparam int DELAY_W    = 31;
   localparam int TIME_W     = 32;
   localparam int ID_W       = 32;
   localparam int PENDING_W  = 5;
   localparam int MAX_FIRE   = 16;
   localparam int FIRE_CNT_W = $clog2(MAX_FIRE + 1);
   localparam int WIDE_CNT_W = 9;   // holds a slot count up to 256

   // action codes as they arrive on the request channel
   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK   = 2'd0,
      ACT_SCHED  = 2'd1,
      ACT_CANCEL = 2'd2,
      ACT_STOP   = 2'd3
   } action_type;

   // classified command, one-hot
   typedef enum logic [3:0] {
      OP_TICK   = 4'b0001,
      OP_SCHED  = 4'b0010,
      OP_CANCEL = 4'b0100,
      OP_STOP   = 4'b1000
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [DELAY_W-1:0] delay;
   } cmd_type;

   typedef struct packed {
      logic                 fired;
      logic [ID_W-1:0]      timer_id;
      logic                 accepted;
      logic [PENDING_W-1:0] pending_total;
      logic                 last;
   } rsp_type;

   function automatic logic [PENDING_W-1:0] sat_pending(input logic [WIDE_CNT_W-1:0] n);
      logic [PENDING_W-1:0] r;
      if (n > WIDE_CNT_W'(31)) begin
         r = PENDING_W'(31);
      end else begin
         r = n[PENDING_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/edtq_ifs.sv -----
// ----------------------------------------------------------------------------
// edtq channel interfaces
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface edtq_req_if import edtq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [DELAY_W-1:0]  delay_ticks;

   modport source (output valid, output action, output delay_ticks, input ready);
   modport sink   (input valid, input action, input delay_ticks, output ready);
endinterface

interface edtq_rsp_if import edtq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 fired;
   logic [ID_W-1:0]      timer_id;
   logic                 accepted;
   logic [PENDING_W-1:0] pending_total;
   logic                 last;

   modport source (output valid, output fired, output timer_id, output accepted,
                   output pending_total, output last, input ready);
   modport sink   (input valid, input fired, input timer_id, input accepted,
                   input pending_total, input last, output ready);
endinterface

// ----- hw/rtl/earliest_deadline_timer_queue.sv -----
// ----------------------------------------------------------------------------
// earliest_deadline_timer_queue: fixed-slot timer queue, earliest deadline out
// Schedules timers, advances time on tick beats and fires due timers in
// deadline order, oldest id first on equal deadlines.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one beat per command: action (tick, schedule, cancel all,
//   stop) and delay_ticks for schedule. rsp_bus returns the result beats:
//   one per fired timer for a tick (none when nothing is due), and exactly
//   one for schedule, cancel all and stop. The final beat of a command has
//   last set.
//   A two-entry command queue sits in front of the engine, so req_bus keeps
//   taking beats until full, while the engine works and while a result beat waits.
//   Steps per command (a scan pass streams the slot memory through its read port):
//     cancel all / stop : decode, then response register
//     schedule          : decode, then a walk to the lowest free slot unless
//                         refused, then response register
//     tick              : a scan pass per fired timer, up to 16, then one more
//                         pass that finds none unless 16 have fired
//   Reset clears all valid bits, time, sequence and the stop flag; slot memory
//   contents are not cleared. When the rsp_bus receiver stalls, the result beat
//   holds in the response register and the engine holds with at most one more
//   beat staged behind it.
// ----------------------------------------------------------------------------
module earliest_deadline_timer_queue import edtq_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   edtq_req_if.sink   req_bus,
   edtq_rsp_if.source rsp_bus
);

   // command handoff between intake and engine
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // accept, classify and queue request beats
   edtq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // run commands against the timer table and drive result beats
   edtq_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_bus)
   );

endmodule

// ----- hw/rtl/edtq_front.sv -----
// ----------------------------------------------------------------------------
// edtq_front: request intake
// Accepts request beats, classifies the action into a one-hot command and
// holds it in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module edtq_front import edtq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   edtq_req_if.sink req,
   output logic     cmd_valid,
   output cmd_type  cmd,
   input  logic     cmd_pop
);

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   cmd_type    push_cmd;

   function automatic op_type classify(input logic [ACTION_W-1:0] code);
      op_type op;
      unique case (action_type'(code))
         ACT_TICK:   op = OP_TICK;
         ACT_SCHED:  op = OP_SCHED;
         ACT_CANCEL: op = OP_CANCEL;
         ACT_STOP:   op = OP_STOP;
         default:    op = OP_TICK;
      endcase
      return op;
   endfunction

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      push_cmd.op    = classify(req.action);
      push_cmd.delay = req.delay_ticks;
      count_in       = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

// ----- hw/rtl/edtq_engine.sv -----
// ----------------------------------------------------------------------------
// edtq_engine: timer table and firing engine
// Runs one command at a time: stores timers, scans the slot memory for the
// earliest due deadline, clears slots and drives the response register.
// ----------------------------------------------------------------------------
module edtq_engine import edtq_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   edtq_rsp_if.source rsp
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FREE  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_FIRE  = 5'b01000,
      S_FLUSH = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [SLOTS-1:0]   slot_valid_ff, slot_valid_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [ID_W-1:0]    nseq_ff, nseq_in;
   logic               halted_ff, halted_in;
   logic [ID_W-1:0]    sched_id_ff, sched_id_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [FIRE_CNT_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic               held_valid_ff, held_valid_in;
   rsp_type            held_ff, held_in;

   // slot memory: deadline in the upper half, id in the lower half
   logic [TIME_W+ID_W-1:0] slot_mem [SLOTS];
   logic [TIME_W+ID_W-1:0] rd_data_ff;
   logic                   mem_we;
   logic [TIME_W-1:0]      rd_deadline;
   logic [ID_W-1:0]        rd_id;
   logic [TIME_W-1:0]      rd_diff;

   // scan pipeline
   logic               scan_start;
   logic               issuing_ff;
   logic [IDX_W-1:0]   scan_addr_ff;
   logic               s1_v_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic               s2_v_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic               s2_due_ff;
   logic [TIME_W-1:0]  s2_late_ff;
   logic [ID_W-1:0]    s2_age_ff;
   logic [ID_W-1:0]    s2_id_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [TIME_W-1:0]  best_late_ff;
   logic [ID_W-1:0]    best_age_ff;
   logic [ID_W-1:0]    best_id_ff;
   logic               better;
   logic               scan_done;

   // response register
   logic               out_valid_ff;
   rsp_type            out_ff;
   logic               out_free;
   logic               emit;
   rsp_type            emit_data;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign scan_done = s2_v_ff && (s2_idx_ff == LAST_IDX);

   assign rd_deadline = rd_data_ff[TIME_W+ID_W-1:ID_W];
   assign rd_id       = rd_data_ff[ID_W-1:0];
   assign rd_diff     = rd_deadline - time_ff;

   assign better = !found_ff || (s2_late_ff > best_late_ff) ||
                   ((s2_late_ff == best_late_ff) && (s2_age_ff > best_age_ff));

   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      cnt_in        = cnt_ff;
      time_in       = time_ff;
      nseq_in       = nseq_ff;
      halted_in     = halted_ff;
      sched_id_in   = sched_id_ff;
      delay_in      = delay_ff;
      free_idx_in   = free_idx_ff;
      fire_cnt_in   = fire_cnt_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      cmd_pop       = 1'b0;
      scan_start    = 1'b0;
      mem_we        = 1'b0;
      emit          = 1'b0;
      emit_data     = held_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.op) inside
                  OP_TICK: begin
                     time_in       = time_ff + TIME_W'(1);
                     fire_cnt_in   = '0;
                     held_valid_in = 1'b0;
                     scan_start    = 1'b1;
                     state_in      = S_SCAN;
                  end
                  OP_SCHED: begin
                     nseq_in     = nseq_ff + ID_W'(1);
                     sched_id_in = nseq_ff;
                     delay_in    = cmd.delay;
                     if (halted_ff || (cnt_ff == FULL_CNT)) begin
                        held_in.fired         = 1'b0;
                        held_in.timer_id      = '0;
                        held_in.accepted      = 1'b0;
                        held_in.pending_total = sat_pending(WIDE_CNT_W'(cnt_ff));
                        held_in.last          = 1'b1;
                        state_in              = S_FLUSH;
                     end else begin
                        free_idx_in = '0;
                        state_in    = S_FREE;
                     end
                  end
                  OP_CANCEL, OP_STOP: begin
                     slot_valid_in = '0;
                     cnt_in        = '0;
                     if (cmd.op == OP_STOP) begin
                        halted_in = 1'b1;
                     end
                     held_in      = '0;
                     held_in.last = 1'b1;
                     state_in     = S_FLUSH;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FREE: begin
            // walk up to the lowest free slot; one exists since the table is not full
            if (!slot_valid_ff[free_idx_ff]) begin
               mem_we                     = 1'b1;
               slot_valid_in[free_idx_ff] = 1'b1;
               cnt_in                     = cnt_ff + CNT_W'(1);
               held_in.fired              = 1'b0;
               held_in.timer_id           = sched_id_ff;
               held_in.accepted           = 1'b1;
               held_in.pending_total      = sat_pending(WIDE_CNT_W'(cnt_ff + CNT_W'(1)));
               held_in.last               = 1'b1;
               state_in                   = S_FLUSH;
            end else begin
               free_idx_in = free_idx_ff + IDX_W'(1);
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_FIRE;
            end
         end
         S_FIRE: begin
            if (found_ff) begin
               if (!held_valid_ff || out_free) begin
                  // an earlier firing is known not to be the final one now
                  if (held_valid_ff) begin
                     emit           = 1'b1;
                     emit_data.last = 1'b0;
                  end
                  slot_valid_in[best_idx_ff] = 1'b0;
                  cnt_in                     = cnt_ff - CNT_W'(1);
                  held_in.fired              = 1'b1;
                  held_in.timer_id           = best_id_ff;
                  held_in.accepted           = 1'b0;
                  held_in.pending_total      = sat_pending(WIDE_CNT_W'(cnt_ff - CNT_W'(1)));
                  held_in.last               = 1'b0;
                  held_valid_in              = 1'b1;
                  fire_cnt_in                = fire_cnt_ff + FIRE_CNT_W'(1);
                  if (fire_cnt_ff == FIRE_CNT_W'(MAX_FIRE - 1)) begin
                     state_in = S_FLUSH;
                  end else begin
                     scan_start = 1'b1;
                     state_in   = S_SCAN;
                  end
               end
            end else if (held_valid_ff) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.last = 1'b1;
               held_valid_in  = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[free_idx_ff] <= {time_ff + TIME_W'(delay_ff), sched_id_ff};
      end
      rd_data_ff <= slot_mem[scan_addr_ff];
   end

   // scan datapath
   always_ff @(posedge clock) begin
      s1_idx_ff  <= scan_addr_ff;
      s2_idx_ff  <= s1_idx_ff;
      s2_due_ff  <= slot_valid_ff[s1_idx_ff] && ((rd_diff == '0) || rd_diff[TIME_W-1]);
      s2_late_ff <= time_ff - rd_deadline;
      s2_age_ff  <= nseq_ff - rd_id;
      s2_id_ff   <= rd_id;
      if (s2_v_ff && s2_due_ff && better) begin
         best_idx_ff  <= s2_idx_ff;
         best_late_ff <= s2_late_ff;
         best_age_ff  <= s2_age_ff;
         best_id_ff   <= s2_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff   <= 1'b0;
         scan_addr_ff <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         s1_v_ff <= issuing_ff;
         s2_v_ff <= s1_v_ff;
         if (scan_start) begin
            issuing_ff   <= 1'b1;
            scan_addr_ff <= '0;
            found_ff     <= 1'b0;
         end else begin
            if (issuing_ff) begin
               if (scan_addr_ff == LAST_IDX) begin
                  issuing_ff <= 1'b0;
               end else begin
                  scan_addr_ff <= scan_addr_ff + IDX_W'(1);
               end
            end
            if (s2_v_ff && s2_due_ff) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         cnt_ff        <= '0;
         time_ff       <= '0;
         nseq_ff       <= '0;
         halted_ff     <= 1'b0;
         fire_cnt_ff   <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         cnt_ff        <= cnt_in;
         time_ff       <= time_in;
         nseq_ff       <= nseq_in;
         halted_ff     <= halted_in;
         fire_cnt_ff   <= fire_cnt_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sched_id_ff <= sched_id_in;
      delay_ff    <= delay_in;
      free_idx_ff <= free_idx_in;
      held_ff     <= held_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= emit_data;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.fired         = out_ff.fired;
   assign rsp.timer_id      = out_ff.timer_id;
   assign rsp.accepted      = out_ff.accepted;
   assign rsp.pending_total = out_ff.pending_total;
   assign rsp.last          = out_ff.last;

endmodule

// ----- hw/rtl/edtq_checker.sv -----
// ----------------------------------------------------------------------------
// edtq_checker: port-level checks of the timer queue
// Watches the response channel for result ordering and field consistency.
// ----------------------------------------------------------------------------
module edtq_checker #(
   parameter int SLOTS = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_fired,
   input logic [31:0] rsp_timer_id,
   input logic        rsp_accepted,
   input logic [4:0]  rsp_pending_total,
   input logic        rsp_last
);

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // schedule, cancel and stop give a single beat
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fired) |-> rsp_last)
      else $error("non-firing result without last");

   // a fired timer is never an accepted schedule and leaves a free slot
   a_fire_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fired) |-> (!rsp_accepted && (int'(rsp_pending_total) < SLOTS)))
      else $error("fired result with bad fields");

   // an accepted schedule leaves at least one timer pending
   a_sched_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_pending_total != 5'd0))
      else $error("accepted schedule with zero pending");

   // a stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_timer_id) && $stable(rsp_last) && $stable(rsp_fired)))
      else $error("result beat changed while stalled");

endmodule

bind earliest_deadline_timer_queue edtq_checker #(
   .SLOTS (SLOTS)
) u_edtq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_fired         (rsp_bus.fired),
   .rsp_timer_id      (rsp_bus.timer_id),
   .rsp_accepted      (rsp_bus.accepted),
   .rsp_pending_total (rsp_bus.pending_total),
   .rsp_last          (rsp_bus.last)
);
